// ----- hdl/avg_pkg.sv -----
// avg_pkg: shared constants, CORDIC arctangent table and the controller/datapath
// command and status structures of the arc vertex generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package avg_pkg;

   localparam int MAX_POINTS_DEF   = 64;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_LEN         = 24;
   localparam int AUTO_MIN         = 10;

   localparam int REQ_DATA_W = 184;
   localparam int RSP_DATA_W = 88;

   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic [17:0]        PI_Q16      = 18'd205887;

   typedef struct packed {
      logic load;
      logic sq;
      logic root_start;
      logic scale;
      logic count;
      logic prod;
      logic div_start;
      logic rot_start;
      logic pmul;
      logic emit;
      logic next_vertex;
      logic advance;
   } avg_cmd_type;

   typedef struct packed {
      logic auto_cnt;
      logic root_done;
      logic n_small;
      logic div_done;
      logic rot_done;
      logic out_free;
      logic last_vertex;
   } avg_status_type;

   function automatic logic [31:0] atan_turns(input logic [4:0] k);
      logic [31:0] v;
      case (k)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/avg_div.sv -----
// avg_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module avg_div #(
   parameter int NUM_W = 28,
   parameter int DEN_W = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic      [NUM_W-1:0] quot,
   output logic                  done
);
   localparam int CW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in, den_ff;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      trial   = {rem_ff, num_ff[NUM_W-1]};
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         num_in  = num;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NUM_W - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      if (start) den_ff <= den;
   end

   assign quot = num_ff;
   assign done = !busy_ff;
endmodule
`default_nettype wire

// ----- hdl/avg_dp.sv -----
// avg_dp: datapath of the arc vertex generator: input registers, point count,
// square root, angle and color dividers, CORDIC rotation and output register.
// Depends on avg_pkg and avg_div.
`timescale 1ns / 1ps
`default_nettype none
module avg_dp import avg_pkg::*; #(
   parameter int MAX_POINTS   = MAX_POINTS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire avg_cmd_type           cmd,
   output avg_status_type             st,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  rsp_tready,
   output logic                       rsp_tvalid,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tuser,
   output logic                       rsp_tlast
);
   localparam int IW  = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
   localparam int NW  = $clog2(MAX_POINTS + 1);
   localparam int PW  = IW + 22;
   localparam int CNW = 8 + IW + 1;
   localparam int CS  = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

   // input registers
   logic signed [15:0] cx_ff, cy_ff;
   logic [15:0]        w_ff, h_ff;
   logic signed [20:0] a0_ff, a1_ff;
   logic [31:0]        bc_ff, ec_ff;
   logic [7:0]         pc_ff;

   // count and vertex state
   logic [32:0]    sq_ff;
   logic [12:0]    auto_ff;
   logic [NW-1:0]  n_ff;
   logic [IW-1:0]  d_ff, i_ff;
   logic [15:0]    base_ff;

   // square root
   logic [33:0] rad_ff;
   logic [19:0] srem_ff;
   logic [16:0] root_ff;
   logic [4:0]  scnt_ff;
   logic        sbusy_ff;
   logic [19:0] srem_sh, strial;

   // dividers
   logic [PW-1:0]  amag_ff, aquot;
   logic           aneg_ff;
   logic [CNW-1:0] cnum_ff [4];
   logic [CNW-1:0] cquot   [4];
   logic [4:0]     ddone;

   // CORDIC
   logic signed [32:0] x_ff, y_ff, z_ff, xs, ys;
   logic [4:0]         k_ff;
   logic               rbusy_ff;
   logic [1:0]         q_ff;
   logic [15:0]        ang16, qa16, a_plus;
   logic [1:0]         qd;
   logic signed [15:0] rres;

   // position products
   logic signed [49:0] px_ff, py_ff;
   logic signed [32:0] cv, sv;

   // output register
   logic                  vld_ff;
   logic [RSP_DATA_W-1:0] dat_ff;
   logic                  usr_ff, lst_ff;

   logic [34:0]         scale_p;
   logic [12:0]         n_pick;
   logic signed [21:0]  span;
   logic signed [PW:0]  aprod;
   logic [16:0]         posx, posy;
   logic [31:0]         col;

   function automatic logic [16:0] place(input logic signed [15:0] c,
                                         input logic signed [49:0] p);
      logic signed [49:0] t;
      logic signed [19:0] v;
      t = p + (50'sd1 <<< 30);
      v = 20'(c) + 20'($signed(t[49:31]));
      if (v > 20'sd65535) v = 20'sd65535;
      if (v < -20'sd65536) v = -20'sd65536;
      return v[16:0];
   endfunction

   // square root step
   always_comb begin
      srem_sh = {srem_ff[17:0], rad_ff[33:32]};
      strial  = {1'b0, root_ff, 2'b01};
   end

   assign scale_p = root_ff * PI_Q16;
   assign n_pick  = (pc_ff == 8'd0) ?
                    ((auto_ff < 13'(AUTO_MIN)) ? 13'(AUTO_MIN) : auto_ff) : 13'(pc_ff);
   assign span    = 22'(a1_ff) - 22'(a0_ff);
   assign aprod   = $signed({1'b0, i_ff}) * span;

   // angle assembly and quadrant reduction
   always_comb begin
      qa16   = aneg_ff ? 16'(-aquot) : aquot[15:0];
      ang16  = 16'(a0_ff) + qa16;
      a_plus = ang16 + 16'd8192;
      qd     = a_plus[15:14];
      rres   = $signed(ang16 - {qd, 14'b0});
      xs     = x_ff >>> k_ff;
      ys     = y_ff >>> k_ff;
   end

   always_comb begin
      case (q_ff)
         2'd0: begin cv = x_ff;  sv = y_ff;  end
         2'd1: begin cv = -y_ff; sv = x_ff;  end
         2'd2: begin cv = -x_ff; sv = -y_ff; end
         default: begin cv = y_ff; sv = -x_ff; end
      endcase
   end

   always_comb begin
      posx = place(cx_ff, px_ff);
      posy = place(cy_ff, py_ff);
      for (int c = 0; c < 4; c++) col[c*8 +: 8] = cquot[c][7:0];
   end

   avg_div #(.NUM_W(PW), .DEN_W(IW)) u_adiv (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .num(amag_ff), .den(d_ff), .quot(aquot), .done(ddone[4])
   );

   for (genvar g = 0; g < 4; g++) begin : g_cdiv
      avg_div #(.NUM_W(CNW), .DEN_W(IW)) u_cdiv (
         .clock(clock), .reset(reset), .start(cmd.div_start),
         .num(cnum_ff[g]), .den(d_ff), .quot(cquot[g]), .done(ddone[g])
      );
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff <= req_tdata[15:0];
         cy_ff <= req_tdata[31:16];
         w_ff  <= req_tdata[47:32];
         h_ff  <= req_tdata[63:48];
         a0_ff <= req_tdata[84:64];
         a1_ff <= req_tdata[105:85];
         bc_ff <= req_tdata[137:106];
         ec_ff <= req_tdata[169:138];
         pc_ff <= req_tdata[177:170];
      end
      if (cmd.sq) sq_ff <= 33'(w_ff * w_ff) + 33'(h_ff * h_ff);
      if (cmd.scale) auto_ff <= scale_p[34:22];
      if (cmd.count) begin
         n_ff <= (n_pick > 13'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(n_pick);
         d_ff <= (n_pick > 13'(MAX_POINTS)) ? IW'(MAX_POINTS - 1) : IW'(n_pick - 13'd1);
      end
      if (cmd.prod) begin
         aneg_ff <= aprod[PW];
         amag_ff <= aprod[PW] ? PW'(-aprod) : aprod[PW-1:0];
         for (int c = 0; c < 4; c++)
            cnum_ff[c] <= CNW'(bc_ff[c*8 +: 8] * (d_ff - i_ff))
                          + CNW'(ec_ff[c*8 +: 8] * i_ff) + CNW'(d_ff >> 1);
      end
      if (cmd.pmul) begin
         px_ff <= cv * $signed({1'b0, w_ff});
         py_ff <= sv * $signed({1'b0, h_ff});
      end
      // square root datapath
      if (cmd.root_start) begin
         rad_ff  <= {1'b0, sq_ff};
         srem_ff <= '0;
         root_ff <= '0;
      end else if (sbusy_ff) begin
         rad_ff <= {rad_ff[31:0], 2'b00};
         if (srem_sh >= strial) begin
            srem_ff <= srem_sh - strial;
            root_ff <= {root_ff[15:0], 1'b1};
         end else begin
            srem_ff <= srem_sh;
            root_ff <= {root_ff[15:0], 1'b0};
         end
      end
      // CORDIC datapath
      if (cmd.rot_start) begin
         x_ff <= CORDIC_GAIN;
         y_ff <= '0;
         z_ff <= {17'(rres), 16'b0};
         q_ff <= qd;
      end else if (rbusy_ff) begin
         if (!z_ff[32]) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - $signed({1'b0, atan_turns(k_ff)});
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + $signed({1'b0, atan_turns(k_ff)});
         end
      end
      if (cmd.emit) begin
         dat_ff <= {6'b0, col, posy, posx, 16'(base_ff + 16'(i_ff))};
         usr_ff <= (i_ff != '0);
         lst_ff <= (i_ff == d_ff);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         i_ff     <= '0;
         sbusy_ff <= 1'b0;
         scnt_ff  <= '0;
         rbusy_ff <= 1'b0;
         k_ff     <= '0;
         vld_ff   <= 1'b0;
      end else begin
         if (cmd.count) i_ff <= '0;
         else if (cmd.next_vertex) i_ff <= i_ff + 1'b1;
         if (cmd.advance) base_ff <= base_ff + 16'(n_ff);
         if (cmd.root_start) begin
            sbusy_ff <= 1'b1;
            scnt_ff  <= '0;
         end else if (sbusy_ff) begin
            scnt_ff <= scnt_ff + 1'b1;
            if (scnt_ff == 5'd16) sbusy_ff <= 1'b0;
         end
         if (cmd.rot_start) begin
            rbusy_ff <= 1'b1;
            k_ff     <= '0;
         end else if (rbusy_ff) begin
            k_ff <= k_ff + 1'b1;
            if (k_ff == 5'(CS - 1)) rbusy_ff <= 1'b0;
         end
         if (cmd.emit) vld_ff <= 1'b1;
         else if (rsp_tready) vld_ff <= 1'b0;
      end
   end

   always_comb begin
      st.auto_cnt    = (pc_ff == 8'd0);
      st.root_done   = !sbusy_ff;
      st.n_small     = (n_ff < NW'(3));
      st.div_done    = &ddone;
      st.rot_done    = !rbusy_ff;
      st.out_free    = !vld_ff || rsp_tready;
      st.last_vertex = (i_ff == d_ff);
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = dat_ff;
   assign rsp_tuser  = usr_ff;
   assign rsp_tlast  = lst_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!vld_ff || rsp_tready))
      else $error("vertex emitted over a pending result");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> (&ddone))
      else $error("divider restarted while busy");
   a_rot_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.rot_start |-> !rbusy_ff)
      else $error("rotation restarted while busy");
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      cmd.next_vertex |-> (i_ff < d_ff))
      else $error("vertex index past end of arc");
endmodule
`default_nettype wire

// ----- hdl/avg_ctrl.sv -----
// avg_ctrl: sequencer of the arc vertex generator; steps each arc through
// count selection and each vertex through divide, rotate and emit.
// Depends on avg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module avg_ctrl import avg_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire avg_status_type st,
   output avg_cmd_type         cmd
);
   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_SQ     = 13'b0000000000010,
      S_ROOTGO = 13'b0000000000100,
      S_ROOT   = 13'b0000000001000,
      S_SCALE  = 13'b0000000010000,
      S_COUNT  = 13'b0000000100000,
      S_CHECK  = 13'b0000001000000,
      S_PROD   = 13'b0000010000000,
      S_DIVGO  = 13'b0000100000000,
      S_DIV    = 13'b0001000000000,
      S_ROT    = 13'b0010000000000,
      S_PMUL   = 13'b0100000000000,
      S_EMIT   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = (state_ff == S_IDLE) && !reset;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load = 1'b1;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            cmd.sq   = 1'b1;
            state_in = st.auto_cnt ? S_ROOTGO : S_COUNT;
         end
         S_ROOTGO: begin
            cmd.root_start = 1'b1;
            state_in       = S_ROOT;
         end
         S_ROOT: begin
            if (st.root_done) state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_COUNT;
         end
         S_COUNT: begin
            cmd.count = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            state_in = st.n_small ? S_IDLE : S_PROD;
         end
         S_PROD: begin
            cmd.prod = 1'b1;
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (st.div_done) begin
               cmd.rot_start = 1'b1;
               state_in      = S_ROT;
            end
         end
         S_ROT: begin
            if (st.rot_done) state_in = S_PMUL;
         end
         S_PMUL: begin
            cmd.pmul = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               if (st.last_vertex) begin
                  cmd.advance = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  cmd.next_vertex = 1'b1;
                  state_in        = S_PROD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (state_ff == S_IDLE))
      else $error("request taken outside idle");
   a_emit_one: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (cmd.advance != cmd.next_vertex))
      else $error("emit must either advance the arc or the vertex");
   a_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == S_SQ))
      else $error("accepted request not sequenced");
endmodule
`default_nettype wire

// ----- hdl/arc_vertex_generator.sv -----
// arc_vertex_generator: top level; joins the sequencer and the datapath.
// Depends on avg_pkg, avg_ctrl, avg_dp (and avg_div below it).
`timescale 1ns / 1ps
`default_nettype none
// Turns one elliptic arc request into a line strip of N vertices, spaced evenly
// in angle from begin_angle to end_angle inclusive. N is point_count saturated to
// MAX_POINTS, or for a count of zero max(10, pi*diagonal/64) saturated the same way;
// arcs with fewer than three points produce nothing. Each vertex carries a 16-bit
// running index that wraps, a flag for a segment to the previous vertex (tuser)
// and tlast on the final vertex. A request is taken only while no arc is in work.
// Each arc goes through setup, with a bit-serial square root for an automatic count;
// each vertex then goes through the one-bit-per-cycle angle divider and the
// iterative CORDIC rotation. Each result sits in an output register, so the next
// vertex is computed while the previous one waits to be taken.
module arc_vertex_generator import avg_pkg::*; #(
   parameter int MAX_POINTS   = MAX_POINTS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // center_x[15:0] center_y[31:16] width[47:32] height[63:48] begin_angle[84:64]
   // end_angle[105:85] begin_color[137:106] end_color[169:138] point_count[177:170]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // vertex_index[15:0] pos_x[32:16] pos_y[49:33] color[81:50]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // segment_from_previous
   output logic                       rsp_tuser,
   output logic                       rsp_tlast
);
   avg_cmd_type    cmd;
   avg_status_type st;

   // sequence arcs and vertices
   avg_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .st(st), .cmd(cmd)
   );

   // hold the request, compute each vertex, drive the result register
   avg_dp #(.MAX_POINTS(MAX_POINTS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .st(st),
      .req_tdata(req_tdata), .rsp_tready(rsp_tready), .rsp_tvalid(rsp_tvalid),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );
endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// tb: self-checking testbench for arc_vertex_generator; predicts every vertex of
// each arc request and compares it against the response stream.
// Depends on avg_pkg and the arc_vertex_generator RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import avg_pkg::*;

   localparam int N_LIMIT    = MAX_POINTS_DEF;
   localparam int ROT_STEPS  = (CORDIC_STEPS_DEF > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS_DEF;
   localparam int TIMEOUT    = 2000000;
   localparam int DRAIN_WAIT = 200;
   localparam int HOLD_OFF   = 600;

   typedef struct {
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic [15:0]        width;
      logic [15:0]        height;
      logic signed [20:0] begin_angle;
      logic signed [20:0] end_angle;
      logic [31:0]        begin_color;
      logic [31:0]        end_color;
      logic [7:0]         point_count;
   } arc_t;

   typedef struct {
      logic [15:0]        vertex_index;
      logic signed [16:0] pos_x;
      logic signed [16:0] pos_y;
      logic [31:0]        color;
      logic               segment;
      logic               last;
   } vertex_t;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   vertex_t     pending_vertices[$];
   logic [15:0] next_index;
   int          fail_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct;
   int          recv_idle_pct;
   logic        rsp_hold = 1'b0;
   event        hold_off_start;

   arc_vertex_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------
   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic longint signed atan_entry(input int k);
      longint signed tab[24];
      tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
              10679838, 5340245, 2670163, 1335087, 667544, 333772,
              166886, 83443, 41722, 20861, 10430, 5215,
              2608, 1304, 652, 326, 163, 81};
      return tab[k];
   endfunction

   // Reduce to the nearest quarter turn, rotate the residual, then swap/negate.
   task automatic rotate_angle(input logic [15:0] ang, output longint signed cos_v,
                               output longint signed sin_v);
      int            quad;
      longint signed resid, x, y, z, nx;
      quad  = ((int'(ang) + 8192) >> 14) & 3;
      resid = longint'(ang) - quad * 16384;
      if (resid >= 32768) resid = resid - 65536;
      z = resid * 65536;
      x = 652032874;
      y = 0;
      for (int k = 0; k < ROT_STEPS; k++) begin
         if (z >= 0) begin
            nx = x - (y >>> k);
            y  = y + (x >>> k);
            z  = z - atan_entry(k);
         end else begin
            nx = x + (y >>> k);
            y  = y - (x >>> k);
            z  = z + atan_entry(k);
         end
         x = nx;
      end
      case (quad)
         0: begin cos_v = x;  sin_v = y;  end
         1: begin cos_v = -y; sin_v = x;  end
         2: begin cos_v = -x; sin_v = -y; end
         default: begin cos_v = y; sin_v = -x; end
      endcase
   endtask

   function automatic logic signed [16:0] place_coord(input longint signed center,
                                                      input longint signed trig,
                                                      input longint signed size);
      longint signed v;
      v = center + ((trig * size + (64'sd1 <<< 30)) >>> 31);
      if (v > 65535) v = 65535;
      if (v < -65536) v = -65536;
      return v[16:0];
   endfunction

   // Expand one arc into its vertices and queue them; advance the running index.
   task automatic tessellate_arc(input arc_t arc);
      longint unsigned n, d, w, h, b, e, ch;
      longint signed   span, ang, cos_v, sin_v;
      vertex_t         vtx;
      w = 64'(arc.width);
      h = 64'(arc.height);
      n = 64'(arc.point_count);
      if (n == 0) begin
         n = (int_sqrt(w * w + h * h) * 205887) >> 22;
         if (n < 64'(AUTO_MIN)) n = 64'(AUTO_MIN);
      end
      if (n > 64'(N_LIMIT)) n = 64'(N_LIMIT);
      if (n < 3) return;
      d    = n - 1;
      span = longint'(arc.end_angle) - longint'(arc.begin_angle);
      for (longint unsigned i = 0; i < n; i++) begin
         ang = longint'(arc.begin_angle) + (longint'(i) * span) / longint'(d);
         rotate_angle(ang[15:0], cos_v, sin_v);
         for (int sh = 0; sh < 32; sh += 8) begin
            b  = 64'((arc.begin_color >> sh) & 32'hFF);
            e  = 64'((arc.end_color >> sh) & 32'hFF);
            ch = (b * (d - i) + e * i + d / 2) / d;
            vtx.color[sh +: 8] = ch[7:0];
         end
         vtx.vertex_index = next_index + i[15:0];
         vtx.pos_x        = place_coord(arc.center_x, cos_v, arc.width);
         vtx.pos_y        = place_coord(arc.center_y, sin_v, arc.height);
         vtx.segment      = (i > 0);
         vtx.last         = (i == d);
         pending_vertices = {pending_vertices, vtx};
      end
      next_index = next_index + n[15:0];
   endtask

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   // Optionally idle, then offer one request and hold it until taken.
   task automatic send_arc(input arc_t arc);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, arc.point_count, arc.end_color, arc.begin_color,
                     arc.end_angle, arc.begin_angle, arc.height, arc.width,
                     arc.center_y, arc.center_x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tessellate_arc(arc);
   endtask

   function automatic arc_t random_arc();
      arc_t a;
      int   kind;
      a.center_x    = 16'($urandom);
      a.center_y    = 16'($urandom);
      a.width       = 16'($urandom);
      a.height      = 16'($urandom);
      a.begin_angle = 21'($urandom);
      a.end_angle   = 21'($urandom);
      a.begin_color = $urandom;
      a.end_color   = $urandom;
      kind = $urandom_range(99);
      // keep most arcs short so the run stays quick; a few go to the limit
      if (kind < 55)      a.point_count = 8'($urandom_range(3, 16));
      else if (kind < 70) a.point_count = 8'($urandom_range(0, 2));
      else if (kind < 82) begin
         a.point_count = 0;
         a.width       = 16'($urandom_range(0, 1200));
         a.height      = 16'($urandom_range(0, 1200));
      end else if (kind < 92) a.point_count = 8'($urandom_range(17, 64));
      else a.point_count = 8'($urandom);
      if ($urandom_range(3) == 0)
         a.end_angle = 21'(a.begin_angle + 21'($urandom_range(0, 4096)));
      return a;
   endfunction

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_vertices.size() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Response side: check each accepted vertex, then choose the next ready
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      vertex_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_vertices.size() == 0) begin
            $error("unexpected vertex index %0d", rsp_tdata[15:0]);
            fail_count++;
         end else begin
            want = pending_vertices.pop_front();
            if (rsp_tdata[15:0] !== want.vertex_index) begin
               $error("vertex_index expected %0d got %0d", want.vertex_index,
                      rsp_tdata[15:0]);
               fail_count++;
            end
            if (rsp_tdata[32:16] !== want.pos_x) begin
               $error("pos_x expected %0d got %0d", want.pos_x,
                      $signed(rsp_tdata[32:16]));
               fail_count++;
            end
            if (rsp_tdata[49:33] !== want.pos_y) begin
               $error("pos_y expected %0d got %0d", want.pos_y,
                      $signed(rsp_tdata[49:33]));
               fail_count++;
            end
            if (rsp_tdata[81:50] !== want.color) begin
               $error("color expected %h got %h", want.color, rsp_tdata[81:50]);
               fail_count++;
            end
            if (rsp_tuser !== want.segment) begin
               $error("segment_from_previous expected %0d got %0d", want.segment,
                      rsp_tuser);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last expected %0d got %0d", want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
      // hold off while the long stall runs, otherwise stall at the current idle rate
      if (rsp_hold) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Long receiver stall, counted in cycles once started.
   always begin
      @(hold_off_start);
      rsp_hold <= 1'b1;
      repeat (HOLD_OFF) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= TIMEOUT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_directed();
      arc_t a;
      a = '{center_x: 0, center_y: 0, width: 16'd320, height: 16'd160,
            begin_angle: 0, end_angle: 21'sd65536, begin_color: 32'h00000000,
            end_color: 32'hFFFFFFFF, point_count: 8'd9};
      send_arc(a);
      // fewest points that still emit, and the counts that emit nothing
      a.point_count = 3;  send_arc(a);
      a.point_count = 2;  send_arc(a);
      a.point_count = 1;  send_arc(a);
      // explicit counts at and past the limit
      a.point_count = 64;  send_arc(a);
      a.point_count = 255; send_arc(a);
      // automatic count: tiny ellipse gives the floor of ten, huge one saturates
      a.point_count = 0; a.width = 0; a.height = 0; send_arc(a);
      a.width = 16'hFFFF; a.height = 16'hFFFF;   send_arc(a);
      a.width = 16'd2000; a.height = 16'd300;    send_arc(a);
      // position saturation on both ends
      a = '{center_x: 16'sh7FFF, center_y: 16'sh8000, width: 16'hFFFF,
            height: 16'hFFFF, begin_angle: 0, end_angle: 21'sd65535,
            begin_color: 32'hFF00FF00, end_color: 32'h00FF00FF, point_count: 8'd8};
      send_arc(a);
      a.center_x = 16'sh8000; a.center_y = 16'sh7FFF; send_arc(a);
      // equal angles: every vertex on the same spot
      a.begin_angle = 21'sd12345; a.end_angle = 21'sd12345; send_arc(a);
      // extreme angles, reversed sweep
      a.begin_angle = 21'sh0FFFFF; a.end_angle = 21'sh100000; send_arc(a);
      a.begin_angle = 21'sh100000; a.end_angle = 21'sh0FFFFF; send_arc(a);
      // quarter-turn boundaries
      a.center_x = 0; a.center_y = 0; a.width = 16'd1000; a.height = 16'd1000;
      a.begin_angle = 21'sd8192; a.end_angle = 21'sd8192 + 21'sd49152;
      a.point_count = 4; send_arc(a);
      a.begin_angle = -21'sd8193; a.end_angle = 21'sd57343; send_arc(a);
      drain();
   endtask

   task automatic test_random(input int items);
      for (int i = 0; i < items; i++) send_arc(random_arc());
      drain();
   endtask

   // Stop taking vertices for a long stretch while requests keep coming.
   task automatic test_backpressure();
      arc_t a;
      -> hold_off_start;
      for (int i = 0; i < 6; i++) begin
         a = random_arc();
         a.point_count = 8'($urandom_range(3, 10));
         send_arc(a);
      end
      drain();
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      next_index    = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      send_idle_pct = 22; recv_idle_pct = 62;
      test_random(33);
      send_idle_pct = 62; recv_idle_pct = 22;
      test_random(33);
      send_idle_pct = 0;  recv_idle_pct = 0;
      test_random(32);
      test_backpressure();

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- arc_vertex_generator.f -----
hdl/avg_pkg.sv
hdl/avg_div.sv
hdl/avg_dp.sv
hdl/avg_ctrl.sv
hdl/arc_vertex_generator.sv
verif/tb.sv
